@@ rtl/can_bus_load_window_monitor_macros.svh @@
// Assertion helpers shared by the top-level and stats RTL files.
`ifndef CAN_BUS_LOAD_WINDOW_MONITOR_MACROS_SVH
`define CAN_BUS_LOAD_WINDOW_MONITOR_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define CBLWM_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define CBLWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sequence violated");

`endif

@@ rtl/cblwm_pkg.sv @@
package cblwm_pkg;

	// Window length default, in accepted sample ticks
	localparam int unsigned WINDOW_DEFAULT = 100;
	localparam int unsigned PERCENT_SCALE  = 100;

	// Width of the APB address and data
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// Register indexes (address bit 2)
	localparam logic REG_MONITOR_ENABLE = 1'b0;
	localparam logic REG_PRECISE_MODE   = 1'b1;

	// Input item kinds
	typedef enum logic {
		KIND_SAMPLE  = 1'b0,
		KIND_RESTART = 1'b1
	} kind_t;

	// Configuration register contents
	typedef struct packed {
		logic monitor_enable;
		logic precise_mode;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic        tick_active;
		logic        window_done;
		logic [6:0]  usage_percent;
		logic [7:0]  window_active_count;
		logic [31:0] rise_count;
		logic [31:0] sample_count;
	} result_t;

endpackage

@@ rtl/can_bus_load_window_monitor.sv @@
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  kind, rec_value, err_passive, bus_off
// output    out        out_valid/out_stall tick_active, window_done, usage_percent,
//                                          window_active_count, rise_count, sample_count
// config    in         APB write/read     monitor_enable (0x0), precise_mode (0x4)
//
// One item per cycle sustained while the output is not stalled.
// Stage one registers the item; the stats update and result capture share one edge.
// Reset clears configuration and all statistics; no clearing pass is needed.
// A stalled output holds the result; the input stage fills and then stalls upstream.
`include "can_bus_load_window_monitor_macros.svh"

module can_bus_load_window_monitor #(
	parameter int unsigned WINDOW = cblwm_pkg::WINDOW_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cblwm_pkg::ADDR_W-1:0]    paddr,
	input  logic [cblwm_pkg::DATA_W-1:0]    pwdata,
	output logic [cblwm_pkg::DATA_W-1:0]    prdata,
	output logic                            pready,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [7:0]                      rec_value,
	input  logic                            err_passive,
	input  logic                            bus_off,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            tick_active,
	output logic                            window_done,
	output logic [6:0]                      usage_percent,
	output logic [7:0]                      window_active_count,
	output logic [31:0]                     rise_count,
	output logic [31:0]                     sample_count
);
	import cblwm_pkg::*;

	cfg_t       cfg;
	result_t    result, result_s2;
	logic       valid_s1, valid_s2;
	logic       kind_s1, passive_s1, busoff_s1;
	logic [7:0] rec_s1;
	logic       advance, fire, in_xfer;

	// Stage two moves when it is empty or its result is taken
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	cblwm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1    <= kind;
			rec_s1     <= rec_value;
			passive_s1 <= err_passive;
			busoff_s1  <= bus_off;
		end
	end

	cblwm_stats #(
		.WINDOW (WINDOW)
	) u_stats (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.fire          (fire),
		.kind          (kind_s1),
		.rec_value     (rec_s1),
		.err_passive   (passive_s1),
		.bus_off       (busoff_s1),
		.result        (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid           = valid_s2;
	assign tick_active         = result_s2.tick_active;
	assign window_done         = result_s2.window_done;
	assign usage_percent       = result_s2.usage_percent;
	assign window_active_count = result_s2.window_active_count;
	assign rise_count          = result_s2.rise_count;
	assign sample_count        = result_s2.sample_count;

	`CBLWM_ASSERT_ALWAYS(a_stall_needs_item, clk, arst_n, !in_stall || (valid_s1 && valid_s2))
	`CBLWM_ASSERT_NEXT(a_fire_fills_out, clk, arst_n, fire, valid_s2)
	`CBLWM_ASSERT_NEXT(a_blocked_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && valid_s2)

endmodule

@@ rtl/cblwm_regs.sv @@
module cblwm_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cblwm_pkg::ADDR_W-1:0]        paddr,
	input  logic [cblwm_pkg::DATA_W-1:0]        pwdata,
	output logic [cblwm_pkg::DATA_W-1:0]        prdata,
	output logic                                pready,
	output cblwm_pkg::cfg_t                     cfg
);
	import cblwm_pkg::*;

	logic   wr_en;
	logic   reg_idx;
	cfg_t   cfg_q;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	// Register writes, low data bit only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MONITOR_ENABLE: cfg_q.monitor_enable <= pwdata[0];
				REG_PRECISE_MODE:   cfg_q.precise_mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MONITOR_ENABLE: prdata[0] = cfg_q.monitor_enable;
			REG_PRECISE_MODE:   prdata[0] = cfg_q.precise_mode;
			default:            prdata    = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/cblwm_stats.sv @@
`include "can_bus_load_window_monitor_macros.svh"

module cblwm_stats #(
	parameter int unsigned WINDOW = cblwm_pkg::WINDOW_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cblwm_pkg::cfg_t      cfg,
	input  logic                 fire,
	input  logic                 kind,
	input  logic [7:0]           rec_value,
	input  logic                 err_passive,
	input  logic                 bus_off,
	output cblwm_pkg::result_t   result
);
	import cblwm_pkg::*;

	localparam logic [7:0] WIN_LEN = 8'(WINDOW);

	logic [7:0]  prev_rec_q, position_q, running_q, pub_active_q;
	logic [6:0]  pub_pct_q;
	logic [31:0] rise_total_q, sample_total_q;

	logic [7:0]  prev_rec_d, position_d, running_d, pub_active_d;
	logic [6:0]  pub_pct_d;
	logic [31:0] rise_total_d, sample_total_d;

	logic        rise, fall, active, done, enabled;
	logic [7:0]  pos_inc, run_inc;
	logic [6:0]  pct_tab [256];

	// Percent lookup: floor(count * 100 / WINDOW), built at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_pct
		localparam int unsigned PCT = (g * PERCENT_SCALE) / WINDOW;
		assign pct_tab[g] = 7'(PCT);
	end

	assign enabled = cfg.monitor_enable & cfg.precise_mode;
	assign rise    = rec_value > prev_rec_q;
	assign fall    = rec_value < prev_rec_q;
	assign pos_inc = position_q + 8'd1;
	assign run_inc = running_q + 8'(active);

	// Next state for one item
	always_comb begin
		prev_rec_d     = prev_rec_q;
		position_d     = position_q;
		running_d      = running_q;
		pub_active_d   = pub_active_q;
		pub_pct_d      = pub_pct_q;
		rise_total_d   = rise_total_q;
		sample_total_d = sample_total_q;
		active         = 1'b0;
		done           = 1'b0;
		if (kind == KIND_RESTART) begin
			prev_rec_d     = cfg.precise_mode ? rec_value : 8'd0;
			position_d     = '0;
			running_d      = '0;
			pub_active_d   = '0;
			pub_pct_d      = '0;
			rise_total_d   = '0;
			sample_total_d = '0;
		end else if (enabled) begin
			active         = rise | fall | err_passive | bus_off;
			rise_total_d   = rise_total_q + 32'(rise);
			sample_total_d = sample_total_q + 32'd1;
			prev_rec_d     = rec_value;
			running_d      = run_inc;
			position_d     = pos_inc;
			// Window closes: publish and restart
			if (pos_inc >= WIN_LEN) begin
				done         = 1'b1;
				pub_active_d = run_inc;
				pub_pct_d    = pct_tab[run_inc];
				running_d    = '0;
				position_d   = '0;
			end
		end
	end

	// State update on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rec_q     <= '0;
			position_q     <= '0;
			running_q      <= '0;
			pub_active_q   <= '0;
			pub_pct_q      <= '0;
			rise_total_q   <= '0;
			sample_total_q <= '0;
		end else if (fire) begin
			prev_rec_q     <= prev_rec_d;
			position_q     <= position_d;
			running_q      <= running_d;
			pub_active_q   <= pub_active_d;
			pub_pct_q      <= pub_pct_d;
			rise_total_q   <= rise_total_d;
			sample_total_q <= sample_total_d;
		end
	end

	always_comb begin
		result.tick_active         = active;
		result.window_done         = done;
		result.usage_percent       = pub_pct_d;
		result.window_active_count = pub_active_d;
		result.rise_count          = rise_total_d;
		result.sample_count        = sample_total_d;
	end

	`CBLWM_ASSERT_ALWAYS(a_pos_in_window, clk, arst_n, position_q < WIN_LEN)
	`CBLWM_ASSERT_ALWAYS(a_run_le_pos, clk, arst_n, running_q <= position_q)
	`CBLWM_ASSERT_ALWAYS(a_pct_range, clk, arst_n, pub_pct_q <= 7'd100)
	`CBLWM_ASSERT_NEXT(a_restart_clears, clk, arst_n, fire && kind == KIND_RESTART, sample_total_q == 32'd0 && position_q == 8'd0 && rise_total_q == 32'd0)

endmodule

@@ test/can_bus_load_window_monitor_tb.sv @@
`timescale 1ns / 1ps

module can_bus_load_window_monitor_tb;
	import cblwm_pkg::*;

	localparam int unsigned WIN         = WINDOW_DEFAULT;
	localparam int unsigned IDLE_PCT    = 38;
	localparam int unsigned HOLD_CYCLES = 100;
	localparam int unsigned HOLD_AT     = 350;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// One tick or restart as offered on the input channel
	typedef struct packed {
		kind_t      kind;
		logic [7:0] rec;
		logic       passive;
		logic       off;
	} tick_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                kind = KIND_SAMPLE;
	logic [7:0]          rec_value = '0;
	logic                err_passive = 1'b0;
	logic                bus_off = 1'b0;

	logic                out_valid;
	logic                out_stall = 1'b1;
	logic                tick_active;
	logic                window_done;
	logic [6:0]          usage_percent;
	logic [7:0]          window_active_count;
	logic [31:0]         rise_count;
	logic [31:0]         sample_count;

	can_bus_load_window_monitor #(
		.WINDOW(WIN)
	) i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.kind               (kind),
		.rec_value          (rec_value),
		.err_passive        (err_passive),
		.bus_off            (bus_off),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.tick_active        (tick_active),
		.window_done        (window_done),
		.usage_percent      (usage_percent),
		.window_active_count(window_active_count),
		.rise_count         (rise_count),
		.sample_count       (sample_count)
	);

	always #10 clk = ~clk;

	// Stimulus backlog and results still owed by the block
	tick_item_t tick_backlog[$];
	result_t    usage_due[$];

	// Predictor copy of configuration and statistics
	logic        mon_cfg, prec_cfg;
	logic [7:0]  last_rec, win_pos, win_active, pub_active;
	logic [6:0]  pub_percent;
	logic [31:0] rise_cnt, tick_cnt;

	logic        no_gaps = 1'b0;
	logic [7:0]  gen_rec = '0;
	int unsigned n_err, n_sent, n_got, n_windows, cycle_cnt;
	int unsigned pct_lo = 127, pct_hi = 0;
	int unsigned hold_left;
	logic        hold_done = 1'b0;

	function automatic void clear_usage();
		last_rec = '0;
		win_pos = '0;
		win_active = '0;
		pub_active = '0;
		pub_percent = '0;
		rise_cnt = '0;
		tick_cnt = '0;
	endfunction

	// Advance the predictor by one accepted item and return the result it owes
	function automatic result_t step_usage(tick_item_t t);
		result_t r;
		logic    act;
		logic    done;
		act = 1'b0;
		done = 1'b0;
		if (t.kind == KIND_RESTART) begin
			clear_usage();
			if (prec_cfg)
				last_rec = t.rec;
		end else if (mon_cfg && prec_cfg) begin
			if (t.rec > last_rec)
				rise_cnt = rise_cnt + 1;
			if (t.rec != last_rec || t.passive || t.off)
				act = 1'b1;
			last_rec = t.rec;
			win_active = win_active + 8'(act);
			win_pos = win_pos + 1;
			tick_cnt = tick_cnt + 1;
			if (win_pos >= WIN) begin
				pub_active = win_active;
				pub_percent = 7'((32'(win_active) * PERCENT_SCALE) / WIN);
				win_active = '0;
				win_pos = '0;
				done = 1'b1;
			end
		end
		r.tick_active = act;
		r.window_done = done;
		r.usage_percent = pub_percent;
		r.window_active_count = pub_active;
		r.rise_count = rise_cnt;
		r.sample_count = tick_cnt;
		return r;
	endfunction

	// Input driver: offer backlog items, keep a stalled transfer steady
	always @(posedge clk) begin
		logic offer;
		tick_item_t cur;
		offer = in_valid;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				cur = tick_item_t'({kind, rec_value, err_passive, bus_off});
				usage_due.push_back(step_usage(cur));
				n_sent++;
				offer = 1'b0;
			end
			if (!offer && tick_backlog.size() != 0
					&& (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
				cur = tick_backlog.pop_front();
				kind <= cur.kind;
				rec_value <= cur.rec;
				err_passive <= cur.passive;
				bus_off <= cur.off;
				offer = 1'b1;
			end
		end
		in_valid <= offer;
	end

	// Output monitor: check each transfer, drive stall at random and with one long hold-off
	always @(posedge clk) begin
		result_t want;
		logic    hold;
		if (arst_n && out_valid && !out_stall) begin
			n_got++;
			if (usage_due.size() == 0) begin
				$error("result with no prediction pending");
				n_err++;
			end else begin
				want = usage_due.pop_front();
				if (tick_active !== want.tick_active) begin
					$error("tick_active: expected %0d, got %0d", want.tick_active, tick_active);
					n_err++;
				end
				if (window_done !== want.window_done) begin
					$error("window_done: expected %0d, got %0d", want.window_done, window_done);
					n_err++;
				end
				if (usage_percent !== want.usage_percent) begin
					$error("usage_percent: expected %0d, got %0d",
						want.usage_percent, usage_percent);
					n_err++;
				end
				if (window_active_count !== want.window_active_count) begin
					$error("window_active_count: expected %0d, got %0d",
						want.window_active_count, window_active_count);
					n_err++;
				end
				if (rise_count !== want.rise_count) begin
					$error("rise_count: expected %0d, got %0d", want.rise_count, rise_count);
					n_err++;
				end
				if (sample_count !== want.sample_count) begin
					$error("sample_count: expected %0d, got %0d",
						want.sample_count, sample_count);
					n_err++;
				end
				if (want.window_done) begin
					n_windows++;
					if (want.usage_percent < pct_lo)
						pct_lo = want.usage_percent;
					if (want.usage_percent > pct_hi)
						pct_hi = want.usage_percent;
				end
			end
			if (!hold_done && n_got == HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			hold = 1'b1;
		end else begin
			hold = arst_n && !no_gaps && ($urandom_range(99) < IDLE_PCT);
		end
		out_stall <= hold;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("can_bus_load_window_monitor: mismatch");
			$finish;
		end
	end

	// APB write: setup cycle, then access cycle; junk in the unused upper bits
	task automatic reg_write(logic idx, logic val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= {31'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MONITOR_ENABLE)
			mon_cfg = val;
		else
			prec_cfg = val;
	endtask

	task automatic set_config(logic en, logic prec);
		reg_write(REG_MONITOR_ENABLE, en);
		reg_write(REG_PRECISE_MODE, prec);
	endtask

	// Wait until the block has nothing in flight
	task automatic drain();
		while (tick_backlog.size() != 0 || in_valid || usage_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_tick(kind_t k, logic [7:0] rec, logic ep, logic bo);
		tick_backlog.push_back('{k, rec, ep, bo});
	endtask

	// Random ticks; busy_pct sets how many are active, restart_pm is per mille
	task automatic add_random(int n, int unsigned busy_pct, int unsigned restart_pm);
		tick_item_t t;
		for (int i = 0; i < n; i++) begin
			t.kind = KIND_SAMPLE;
			t.passive = 1'b0;
			t.off = 1'b0;
			t.rec = gen_rec;
			if ($urandom_range(999) < restart_pm) begin
				t.kind = KIND_RESTART;
				t.rec = 8'($urandom());
				t.passive = 1'($urandom());
				t.off = 1'($urandom());
			end else if ($urandom_range(99) < busy_pct) begin
				if ($urandom_range(1))
					t.rec = 8'($urandom());
				else
					t.rec = gen_rec + 8'($urandom_range(0, 6)) - 8'd3;
				t.passive = ($urandom_range(3) == 0);
				t.off = ($urandom_range(3) == 0);
				if (t.rec == gen_rec && !t.off)
					t.passive = 1'b1;
			end
			gen_rec = t.rec;
			tick_backlog.push_back(t);
		end
	endtask

	initial begin
		mon_cfg = 1'b0;
		prec_cfg = 1'b0;
		clear_usage();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Both registers off after reset: ticks ignored, restart loads zero
		add_tick(KIND_SAMPLE, 8'hA5, 1'b1, 1'b0);
		add_tick(KIND_RESTART, 8'h5A, 1'b0, 1'b1);
		add_tick(KIND_SAMPLE, 8'hFF, 1'b0, 1'b1);
		drain();
		set_config(1'b1, 1'b0);
		add_tick(KIND_SAMPLE, 8'h33, 1'b1, 1'b1);
		drain();
		// Precise only: restart takes the baseline, ticks still ignored
		set_config(1'b0, 1'b1);
		add_tick(KIND_RESTART, 8'h80, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'h81, 1'b0, 1'b0);
		drain();
		// Both on: no change, rise, fall, each flag, extremes of the counter
		set_config(1'b1, 1'b1);
		add_tick(KIND_SAMPLE, 8'h80, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'h81, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'h00, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'h00, 1'b1, 1'b0);
		add_tick(KIND_SAMPLE, 8'h00, 1'b0, 1'b1);
		add_tick(KIND_SAMPLE, 8'h00, 1'b1, 1'b1);
		add_tick(KIND_SAMPLE, 8'h00, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'hFF, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'hFF, 1'b0, 1'b0);
		add_tick(KIND_RESTART, 8'hFF, 1'b1, 1'b1);
		add_tick(KIND_SAMPLE, 8'hFF, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'h00, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'h7F, 1'b0, 1'b0);
		add_tick(KIND_SAMPLE, 8'h7E, 1'b1, 1'b0);
		add_tick(KIND_RESTART, 8'h00, 1'b0, 1'b0);
		gen_rec = 8'h00;
		drain();

		// Mixed random traffic with full windows and rare restarts
		add_random(300, 45, 8);
		drain();

		// Back to back, no idling: a fully busy window, then a silent one
		no_gaps = 1'b1;
		add_tick(KIND_RESTART, gen_rec, 1'b0, 1'b0);
		add_random(WIN, 100, 0);
		add_random(WIN, 0, 0);
		drain();
		no_gaps = 1'b0;

		// Partial configurations: ticks ignored, restarts still take effect
		set_config(1'b0, 1'b1);
		add_random(40, 60, 50);
		drain();
		set_config(1'b1, 1'b0);
		add_random(40, 60, 50);
		drain();
		set_config(1'b0, 1'b0);
		add_random(30, 60, 50);
		drain();

		// Fully enabled again, activity density varying per chunk
		set_config(1'b1, 1'b1);
		for (int c = 0; c < 7; c++)
			add_random(50, $urandom_range(100), 5);
		drain();
		repeat (8) @(posedge clk);

		$display("Ran %0d transfers in, %0d out; %0d windows closed, usage %0d..%0d percent.",
			n_sent, n_got, n_windows, pct_lo, pct_hi);
		$display("Covered all register settings, restarts, flags, rises, falls and a long stall.");
		if (n_err == 0)
			$display("can_bus_load_window_monitor: match");
		else
			$display("can_bus_load_window_monitor: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cblwm_pkg.sv
rtl/cblwm_regs.sv
rtl/cblwm_stats.sv
rtl/can_bus_load_window_monitor.sv
test/can_bus_load_window_monitor_tb.sv
